// ===== design/sls_pkg.sv =====
// Package for the streaming lexer with semicolon insertion.
// Holds token kinds, the token and bundle types, and the character tables.
// Used by every module of the design; depends on nothing.
package sls_pkg;

    localparam int OFFSET_BITS   = 32;
    localparam int KEYWORD_CHARS = 8;
    localparam int KW_COUNT      = 30;
    localparam int MAX_TOKENS    = 3;
    localparam int QUEUE_DEPTH   = 4;
    localparam int WLEN_BITS     = $clog2(KEYWORD_CHARS + 2);
    localparam int KIDX_BITS     = $clog2(KEYWORD_CHARS);

    typedef logic [OFFSET_BITS-1:0] ofs_t;
    typedef logic [6:0] kind_t;
    typedef logic [WLEN_BITS-1:0] wlen_t;
    typedef logic [KEYWORD_CHARS-1:0][7:0] kbuf_t;

    localparam ofs_t OFS_MAX = '1;

    localparam kind_t K_IDENT        = 7'd0;
    localparam kind_t K_INT          = 7'd1;
    localparam kind_t K_FLOAT        = 7'd2;
    localparam kind_t K_STRING       = 7'd3;
    localparam kind_t K_LAST_TRIGGER = 7'd24;
    localparam kind_t K_SEMI         = 7'd37;
    localparam kind_t K_EOF          = 7'd38;
    localparam kind_t K_INVALID      = 7'd39;
    localparam kind_t K_SLASHEQ      = 7'd61;
    localparam kind_t K_SLASH        = 7'd62;
    localparam kind_t K_DOT          = 7'd64;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef struct packed {
        kind_t kind;
        ofs_t  start;
        ofs_t  stop;
        logic  fin;
    } tok_t;

    typedef struct packed {
        tok_t [MAX_TOKENS-1:0] toks;
        logic [1:0]            cnt;
    } bundle_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] a;
        kind_t      ka;
        logic [7:0] b;
        kind_t      kb;
        kind_t      single;
    } op_t;

    // Keyword text is right-justified: the first character is the highest used byte.
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("fn"), 64'("return"), 64'("let"), 64'("var"), 64'("if"), 64'("else"),
        64'("while"), 64'("for"), 64'("in"), 64'("break"), 64'("continue"),
        64'("test"), 64'("assert"), 64'("true"), 64'("false"), 64'("null"),
        64'("orelse"), 64'("struct"), 64'("i8"), 64'("i16"), 64'("i32"),
        64'("i64"), 64'("u8"), 64'("u16"), 64'("u32"), 64'("u64"), 64'("f32"),
        64'("f64"), 64'("bool"), 64'("void")
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd2, 4'd6, 4'd3, 4'd3, 4'd2, 4'd4, 4'd5, 4'd3, 4'd2, 4'd5, 4'd8, 4'd4,
        4'd6, 4'd4, 4'd5, 4'd4, 4'd6, 4'd6, 4'd2, 4'd3, 4'd3, 4'd3, 4'd2, 4'd3,
        4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4
    };
    localparam kind_t KW_KIND [KW_COUNT] = '{
        7'd25, 7'd7, 7'd26, 7'd27, 7'd28, 7'd29, 7'd30, 7'd31, 7'd32, 7'd8, 7'd9,
        7'd33, 7'd34, 7'd4, 7'd5, 7'd6, 7'd35, 7'd36, 7'd10, 7'd11, 7'd12, 7'd13,
        7'd14, 7'd15, 7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21
    };

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic kind_t word_kind(input kbuf_t kb, input wlen_t wl);
        kind_t      k;
        logic       eq;
        logic [3:0] len;
        k = K_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            len = KW_LEN[i];
            eq  = (wl == WLEN_BITS'(len));
            for (int j = 0; j < KEYWORD_CHARS; j++) begin
                if (j < int'(len) && kb[j] != KW_TEXT[i][8*(int'(len)-1-j) +: 8]) begin
                    eq = 1'b0;
                end
            end
            if (eq) begin
                k = KW_KIND[i];
            end
        end
        return k;
    endfunction

    function automatic op_t op_lookup(input logic [7:0] c);
        op_t o;
        o = '{hit: 1'b1, a: 8'd0, ka: 7'd0, b: 8'd0, kb: 7'd0, single: 7'd0};
        case (c)
            "-": begin o.a = ">"; o.ka = 7'd40; o.b = "="; o.kb = 7'd41; o.single = 7'd42; end
            "=": begin o.a = "="; o.ka = 7'd43; o.single = 7'd44; end
            "!": begin o.a = "="; o.ka = 7'd45; o.single = 7'd46; end
            "<": begin o.a = "="; o.ka = 7'd47; o.b = "<"; o.kb = 7'd48; o.single = 7'd49; end
            ">": begin o.a = "="; o.ka = 7'd50; o.b = ">"; o.kb = 7'd51; o.single = 7'd52; end
            "&": begin o.a = "&"; o.ka = 7'd53; o.single = 7'd54; end
            "|": begin o.a = "|"; o.ka = 7'd55; o.single = 7'd56; end
            "+": begin o.a = "="; o.ka = 7'd57; o.single = 7'd58; end
            "*": begin o.a = "="; o.ka = 7'd59; o.single = 7'd60; end
            ".": begin o.a = "."; o.ka = 7'd63; o.single = K_DOT; end
            default: o.hit = 1'b0;
        endcase
        return o;
    endfunction

    function automatic kind_t punct_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            "(": k = 7'd65;
            ")": k = 7'd22;
            "{": k = 7'd66;
            "}": k = 7'd23;
            "[": k = 7'd67;
            "]": k = 7'd24;
            ",": k = 7'd68;
            ":": k = 7'd69;
            ";": k = K_SEMI;
            "%": k = 7'd70;
            "^": k = 7'd71;
            "~": k = 7'd72;
            "?": k = 7'd73;
            default: k = K_INVALID;
        endcase
        return k;
    endfunction

endpackage

// ===== design/sls_if.sv =====
// Handshake interfaces for source bytes and tokens.
// Depends on nothing.
interface lex_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_marker;
    modport source (output valid, char_code, end_marker, input ready);
    modport sink (input valid, char_code, end_marker, output ready);
endinterface

interface lex_tok_if;
    logic        valid;
    logic        ready;
    logic [6:0]  token_kind;
    logic [31:0] token_start;
    logic [31:0] token_end;
    logic        final_token;
    modport source (output valid, token_kind, token_start, token_end, final_token,
                    input ready);
    modport sink (input valid, token_kind, token_start, token_end, final_token,
                  output ready);
endinterface

// ===== design/sls_front.sv =====
// Front end: takes one byte per cycle unless full, runs the lexer state, builds a token bundle.
// Depends on sls_pkg and lex_in_if.
module sls_front (
    input  logic             clk,
    input  logic             rst_n,
    lex_in_if.sink           src,
    input  logic             full,
    output logic             push,
    output sls_pkg::bundle_t bundle
);
    import sls_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_WORD, M_INT, M_INTDOT, M_FRAC, M_STR, M_STRESC, M_SLASH,
        M_COMMENT, M_OP
    } mode_t;

    mode_t      mode_reg, mode_next;
    ofs_t       pos_reg, pos_next;
    ofs_t       origin_reg, origin_next;
    ofs_t       dot_reg, dot_next;
    logic       semi_reg, semi_next;
    logic [7:0] held_reg, held_next;
    kbuf_t      kbuf_reg, kbuf_next;
    wlen_t      wlen_reg, wlen_next;

    bundle_t    b;
    logic       fire;
    logic       do_op;
    logic       do_idle;
    ofs_t       p;
    ofs_t       p1;
    logic [7:0] c;
    op_t        oe;

    task automatic emit(input kind_t k, input ofs_t s, input ofs_t e, input logic fin,
                        input logic set_semi, inout bundle_t bb, inout logic semi);
        if (bb.cnt < 2'(MAX_TOKENS)) begin
            bb.toks[bb.cnt] = '{kind: k, start: s, stop: e, fin: fin};
            bb.cnt = bb.cnt + 2'd1;
        end
        if (set_semi) begin
            semi = (k <= K_LAST_TRIGGER);
        end
    endtask

    task automatic add_char(input logic [7:0] ch, inout kbuf_t kb, inout wlen_t wl);
        if (wl < WLEN_BITS'(KEYWORD_CHARS)) begin
            kb[wl[KIDX_BITS-1:0]] = ch;
            wl = wl + 1'b1;
        end else begin
            wl = WLEN_BITS'(KEYWORD_CHARS + 1);
        end
    endtask

    assign src.ready = !full;
    assign fire      = src.valid && src.ready;
    assign push      = fire && (b.cnt != 2'd0);
    assign bundle    = b;

    always_comb
    begin
        b           = '0;
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        origin_next = origin_reg;
        dot_next    = dot_reg;
        semi_next   = semi_reg;
        held_next   = held_reg;
        kbuf_next   = kbuf_reg;
        wlen_next   = wlen_reg;
        do_op       = 1'b0;
        do_idle     = 1'b0;
        p           = pos_reg;
        p1          = (pos_reg == OFS_MAX) ? pos_reg : pos_reg + 1'b1;
        c           = src.char_code;
        oe          = op_lookup(held_reg);
        if (!src.end_marker)
        begin
            case (mode_reg)
                M_WORD:
                begin
                    if (is_alpha(c) || is_digit(c))
                    begin
                        add_char(c, kbuf_next, wlen_next);
                    end
                    else
                    begin
                        emit(word_kind(kbuf_reg, wlen_reg), origin_reg, p, 1'b0, 1'b1, b,
                             semi_next);
                        do_idle = 1'b1;
                    end
                end
                M_INT, M_FRAC:
                begin
                    if (mode_reg == M_INT && c == CH_DOT)
                    begin
                        mode_next = M_INTDOT;
                        dot_next  = p;
                    end
                    else if (!(is_digit(c) || c == CH_UNDER))
                    begin
                        emit((mode_reg == M_INT) ? K_INT : K_FLOAT, origin_reg, p, 1'b0,
                             1'b1, b, semi_next);
                        do_idle = 1'b1;
                    end
                end
                M_INTDOT:
                begin
                    if (is_digit(c))
                    begin
                        mode_next = M_FRAC;
                    end
                    else
                    begin
                        emit(K_INT, origin_reg, dot_reg, 1'b0, 1'b1, b, semi_next);
                        held_next   = CH_DOT;
                        origin_next = dot_reg;
                        do_op       = 1'b1;
                    end
                end
                M_STR:
                begin
                    if (c == CH_BSL)
                    begin
                        mode_next = M_STRESC;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        emit(K_STRING, origin_reg, p1, 1'b0, 1'b1, b, semi_next);
                        mode_next = M_IDLE;
                    end
                end
                M_STRESC: mode_next = M_STR;
                M_SLASH:
                begin
                    if (c == CH_SLASH)
                    begin
                        mode_next = M_COMMENT;
                    end
                    else if (c == CH_EQ)
                    begin
                        emit(K_SLASHEQ, origin_reg, p1, 1'b0, 1'b1, b, semi_next);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        emit(K_SLASH, origin_reg, p, 1'b0, 1'b1, b, semi_next);
                        do_idle = 1'b1;
                    end
                end
                M_COMMENT: do_idle = (c == CH_NL);
                M_OP:      do_op = 1'b1;
                default:   do_idle = 1'b1;
            endcase

            if (do_op)
            begin
                oe        = op_lookup(held_next);
                mode_next = M_IDLE;
                if (!oe.hit)
                begin
                    emit(K_INVALID, origin_next, p, 1'b0, 1'b1, b, semi_next);
                    do_idle = 1'b1;
                end
                else if (c == oe.a)
                begin
                    emit(oe.ka, origin_next, p1, 1'b0, 1'b1, b, semi_next);
                end
                else if (oe.kb != 7'd0 && c == oe.b)
                begin
                    emit(oe.kb, origin_next, p1, 1'b0, 1'b1, b, semi_next);
                end
                else
                begin
                    emit(oe.single, origin_next, p, 1'b0, 1'b1, b, semi_next);
                    do_idle = 1'b1;
                end
            end

            if (do_idle)
            begin
                mode_next = M_IDLE;
                if (c == CH_NL)
                begin
                    if (semi_next)
                    begin
                        emit(K_SEMI, p, p1, 1'b0, 1'b0, b, semi_next);
                        semi_next = 1'b0;
                    end
                end
                else if (!(c == CH_SPACE || c == CH_TAB || c == CH_CR))
                begin
                    origin_next = p;
                    if (c == CH_SLASH)
                    begin
                        mode_next = M_SLASH;
                    end
                    else if (is_alpha(c))
                    begin
                        mode_next = M_WORD;
                        wlen_next = '0;
                        add_char(c, kbuf_next, wlen_next);
                    end
                    else if (is_digit(c))
                    begin
                        mode_next = M_INT;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        mode_next = M_STR;
                    end
                    else if (op_lookup(c).hit)
                    begin
                        mode_next = M_OP;
                        held_next = c;
                    end
                    else
                    begin
                        emit(punct_kind(c), p, p1, 1'b0, 1'b1, b, semi_next);
                    end
                end
            end
            pos_next = p1;
        end
        else
        begin
            case (mode_reg)
                M_WORD:
                    emit(word_kind(kbuf_reg, wlen_reg), origin_reg, p, 1'b0, 1'b1, b,
                         semi_next);
                M_INT:    emit(K_INT, origin_reg, p, 1'b0, 1'b1, b, semi_next);
                M_INTDOT:
                begin
                    emit(K_INT, origin_reg, dot_reg, 1'b0, 1'b1, b, semi_next);
                    emit(K_DOT, dot_reg, p, 1'b0, 1'b1, b, semi_next);
                end
                M_FRAC:   emit(K_FLOAT, origin_reg, p, 1'b0, 1'b1, b, semi_next);
                M_STR, M_STRESC:
                    emit(K_STRING, origin_reg, p, 1'b0, 1'b1, b, semi_next);
                M_SLASH:  emit(K_SLASH, origin_reg, p, 1'b0, 1'b1, b, semi_next);
                M_OP:
                    emit(oe.hit ? oe.single : K_INVALID, origin_reg, p, 1'b0, 1'b1, b,
                         semi_next);
                default: ;
            endcase
            if (semi_next)
            begin
                emit(K_SEMI, p, p, 1'b0, 1'b0, b, semi_next);
            end
            emit(K_EOF, p, p, 1'b1, 1'b0, b, semi_next);
            mode_next   = M_IDLE;
            pos_next    = '0;
            origin_next = '0;
            dot_next    = '0;
            semi_next   = 1'b0;
            held_next   = '0;
            wlen_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            origin_reg <= '0;
            dot_reg    <= '0;
            semi_reg   <= 1'b0;
            held_reg   <= '0;
            wlen_reg   <= '0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            origin_reg <= origin_next;
            dot_reg    <= dot_next;
            semi_reg   <= semi_next;
            held_reg   <= held_next;
            wlen_reg   <= wlen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            kbuf_reg <= kbuf_next;
        end
    end

endmodule

// ===== design/sls_queue.sv =====
// Small queue of token bundles between the front end and the output stage.
// Depends on sls_pkg.
module sls_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sls_pkg::bundle_t wdata,
    output logic             full,
    input  logic             pop,
    output logic             nonempty,
    output sls_pkg::bundle_t rdata
);
    import sls_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    bundle_t                mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]    wr_reg, wr_next;
    logic [PTR_BITS-1:0]    rd_reg, rd_next;
    logic [PTR_BITS:0]      count_reg, count_next;

    assign full     = (count_reg == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign rdata    = mem[rd_reg];

    always_comb
    begin
        wr_next    = push ? wr_reg + 1'b1 : wr_reg;
        rd_next    = pop ? rd_reg + 1'b1 : rd_reg;
        count_next = count_reg + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= wdata;
        end
    end

endmodule

// ===== design/sls_back.sv =====
// Output stage: holds one token bundle and hands out its tokens one per cycle while tok.ready is high.
// Depends on sls_pkg and lex_tok_if.
module sls_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             nonempty,
    input  sls_pkg::bundle_t rdata,
    output logic             pop,
    lex_tok_if.source        tok
);
    import sls_pkg::*;

    logic       busy_reg, busy_next;
    bundle_t    bun_reg;
    logic [1:0] idx_reg, idx_next;
    logic       sent;
    logic       last;
    tok_t       cur;

    assign cur             = bun_reg.toks[idx_reg];
    assign tok.valid       = busy_reg;
    assign tok.token_kind  = cur.kind;
    assign tok.token_start = 32'(cur.start);
    assign tok.token_end   = 32'(cur.stop);
    assign tok.final_token = cur.fin;

    assign sent = busy_reg && tok.ready;
    assign last = (idx_reg + 2'd1 == bun_reg.cnt);
    assign pop  = nonempty && (!busy_reg || (sent && last));

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (sent)
        begin
            busy_next = !last;
            idx_next  = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            bun_reg <= rdata;
        end
    end

endmodule

// ===== design/source_lexer_semicolon_insert_top.sv =====
// Top level of the streaming lexer with semicolon insertion.
// Depends on sls_pkg, the interfaces, sls_front, sls_queue and sls_back.
//
//   Port  Direction  Carries
//   src   in         one source byte or the end marker per item
//   tok   out        one token per item: kind, start, end, final flag
//
// The front end takes one byte every cycle while the four-entry bundle queue
// has room. Each byte yields zero to three tokens, and the output stage sends
// one token per cycle while tok.ready is high, so the tokens of one byte go out
// in turn. Reset clears the lexer state, the queue and the output stage. A stalled
// output fills the queue, after which src.ready drops.
module source_lexer_semicolon_insert_top (
    input  logic      clk,
    input  logic      rst_n,
    lex_in_if.sink    src,
    lex_tok_if.source tok
);
    import sls_pkg::*;

    bundle_t wdata;
    bundle_t rdata;
    logic    push;
    logic    pop;
    logic    full;
    logic    nonempty;

    sls_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .src    (src),
        .full   (full),
        .push   (push),
        .bundle (wdata)
    );

    sls_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wdata    (wdata),
        .full     (full),
        .pop      (pop),
        .nonempty (nonempty),
        .rdata    (rdata)
    );

    sls_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .nonempty (nonempty),
        .rdata    (rdata),
        .pop      (pop),
        .tok      (tok)
    );

endmodule
